// ===== rtl/pes_pkg.sv =====
// ----------------------------------------------------------------------------
// pes_pkg
// Shared types, codes and sizes of the polar eye pixel shader.
// ----------------------------------------------------------------------------
package pes_pkg;

  localparam int MAP_RADIUS_D   = 256;
  localparam int DISPLAY_SIZE_D = 512;
  localparam int IRIS_TEX_W_D   = 256;
  localparam int IRIS_TEX_H_D   = 64;
  localparam int SCLERA_TEX_W_D = 256;
  localparam int SCLERA_TEX_H_D = 128;

  localparam int ANGLE_DEPTH = 65536;
  localparam int MUL_W       = 25;
  localparam int SQ_W        = 17;
  localparam int ROOT_W      = 9;

  localparam logic [7:0] ANG_HALF = 8'd128;

  localparam logic [2:0] CFG_CENTER_X   = 3'd0;
  localparam logic [2:0] CFG_CENTER_Y   = 3'd1;
  localparam logic [2:0] CFG_EYE_RADIUS = 3'd2;
  localparam logic [2:0] CFG_IRIS_RADIUS = 3'd3;
  localparam logic [2:0] CFG_PUPIL_RADIUS = 3'd4;
  localparam logic [2:0] CFG_ROTATIONS  = 3'd5;
  localparam logic [2:0] CFG_SOLID_COLORS = 3'd6;
  localparam logic [2:0] CFG_TEX_ENABLE = 3'd7;

  typedef enum logic [1:0] {
    KIND_SHADE  = 2'd0,
    KIND_ANGLE  = 2'd1,
    KIND_IRIS   = 2'd2,
    KIND_SCLERA = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REGION_BG     = 2'd0,
    REGION_PUPIL  = 2'd1,
    REGION_IRIS   = 2'd2,
    REGION_SCLERA = 2'd3
  } region_t;

  typedef struct packed {
    logic [8:0]  center_x;
    logic [8:0]  center_y;
    logic [7:0]  eye_radius;
    logic [7:0]  iris_radius;
    logic [7:0]  pupil_radius;
    logic [15:0] rotations;
    logic [63:0] solid_colors;
    logic [1:0]  texture_enable;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    region_t     region;
    logic [15:0] color;
    logic        tex;
    logic        sclera;
    logic [7:0]  ang;
    logic [15:0] addr;
    logic [15:0] data;
    logic [15:0] ubase;
  } pix_t;

  function automatic int addr_bits(int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// ===== rtl/pes_ram.sv =====
// ----------------------------------------------------------------------------
// pes_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pes_ram
  import pes_pkg::*;
#(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [addr_bits(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic [addr_bits(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pes_recip_div.sv =====
// ----------------------------------------------------------------------------
// pes_recip_div
// Shift-subtract divider forming a constant over an 8-bit divisor, one
// quotient bit per cycle. A zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
module pes_recip_div
  import pes_pkg::*;
#(
  parameter int DIVIDEND = 64 * 65536
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [7:0]       divisor,
  output logic [MUL_W-1:0] quotient,
  output logic             busy
);

  localparam logic [MUL_W-1:0] DVD = MUL_W'(DIVIDEND);

  logic             running;
  logic [4:0]       cnt;
  logic [7:0]       rem;
  logic [7:0]       dsr;
  logic [MUL_W-1:0] quo;
  logic [8:0]       trial;
  logic             qbit;

  assign trial = {rem, DVD[cnt]};
  assign qbit  = (trial >= {1'b0, dsr});
  assign busy  = running;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
    end else if (go) begin
      running <= 1'b1;
    end else if (running && cnt == 5'd0) begin
      running <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      cnt <= 5'(MUL_W - 1);
      rem <= 8'd0;
      dsr <= divisor;
    end else if (running) begin
      cnt <= cnt - 5'd1;
      rem <= qbit ? 8'(trial - {1'b0, dsr}) : trial[7:0];
      quo <= {quo[MUL_W-2:0], qbit};
      if (cnt == 5'd0) begin
        quotient <= (dsr == 8'd0) ? '0 : {quo[MUL_W-2:0], qbit};
      end
    end
  end

endmodule

// ===== rtl/pes_isqrt.sv =====
// ----------------------------------------------------------------------------
// pes_isqrt
// Three-stage digit-by-digit integer square root, three result bits a stage.
// ----------------------------------------------------------------------------
module pes_isqrt
  import pes_pkg::*;
(
  input  logic              clk,
  input  logic [SQ_W-1:0]   n,
  output logic [ROOT_W-1:0] root
);

  typedef struct packed {
    logic [17:0] n;
    logic [10:0] rem;
    logic [8:0]  root;
  } sq_t;

  function automatic sq_t sq_step(sq_t a);
    sq_t         r;
    logic [12:0] acc;
    logic [12:0] trial;
    acc   = {a.rem[10:0], a.n[17:16]};
    trial = {2'b00, a.root, 2'b01};
    r.n   = {a.n[15:0], 2'b00};
    if (acc >= trial) begin
      r.rem  = 11'(acc - trial);
      r.root = {a.root[7:0], 1'b1};
    end else begin
      r.rem  = acc[10:0];
      r.root = {a.root[7:0], 1'b0};
    end
    return r;
  endfunction

  sq_t st [4];

  assign st[0] = '{n: {1'b0, n}, rem: 11'd0, root: 9'd0};

  for (genvar s = 0; s < 3; s++) begin : g_stage
    always_ff @(posedge clk) begin
      st[s+1] <= sq_step(sq_step(sq_step(st[s])));
    end
  end

  assign root = st[3].root;

endmodule

// ===== rtl/pes_front.sv =====
// ----------------------------------------------------------------------------
// pes_front
// Stages one to three: offsets from the eye center, squares, circle and
// region tests, and the quadrant angle lookup with rotation.
// ----------------------------------------------------------------------------
module pes_front
  import pes_pkg::*;
#(
  parameter int MAP_RADIUS   = MAP_RADIUS_D,
  parameter int DISPLAY_SIZE = DISPLAY_SIZE_D
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [1:0]      kind,
  input  logic [8:0]      pixel_x,
  input  logic [8:0]      pixel_y,
  input  logic [15:0]     table_address,
  input  logic [15:0]     table_data,
  input  cfg_t            cfg,
  input  logic [15:0]     eye_sq,
  input  logic [15:0]     pupil_sq,
  input  logic [15:0]     iris_sq,
  output pix_t            pix_out,
  output logic [SQ_W-1:0] n_out
);

  // Stage one.
  pix_t              p1;
  pix_t              p1_c;
  logic signed [9:0] dx1, dy1;
  logic [7:0]        qx1, qy1;
  logic              disp1;

  logic signed [9:0] dx_c, dy_c;
  logic [9:0]        ax_c, ay_c;

  assign dx_c = $signed({1'b0, pixel_x}) - $signed({1'b0, cfg.center_x});
  assign dy_c = $signed({1'b0, pixel_y}) - $signed({1'b0, cfg.center_y});
  assign ax_c = dx_c[9] ? 10'(-dx_c) : 10'(dx_c);
  assign ay_c = dy_c[9] ? 10'(-dy_c) : 10'(dy_c);

  always_comb begin
    p1_c       = '0;
    p1_c.valid = in_valid;
    p1_c.kind  = kind_t'(kind);
    p1_c.addr  = table_address;
    p1_c.data  = table_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1.valid <= 1'b0;
    end else begin
      p1 <= p1_c;
    end
  end

  always_ff @(posedge clk) begin
    dx1   <= dx_c;
    dy1   <= dy_c;
    qx1   <= (ax_c >= 10'(MAP_RADIUS)) ? 8'(MAP_RADIUS - 1) : ax_c[7:0];
    qy1   <= (ay_c >= 10'(MAP_RADIUS)) ? 8'(MAP_RADIUS - 1) : ay_c[7:0];
    disp1 <= ({1'b0, pixel_x} < 10'(DISPLAY_SIZE)) && ({1'b0, pixel_y} < 10'(DISPLAY_SIZE));
  end

  // Angle table sits at stage two so that writes and lookups keep word order.
  logic [15:0] ang_raddr;
  logic [7:0]  ang_rdata;

  assign ang_raddr = 16'(qy1 * MAP_RADIUS + qx1);

  pes_ram #(.WIDTH(8), .DEPTH(ANGLE_DEPTH)) u_angle (
    .clk   (clk),
    .we    (p1.valid && p1.kind == KIND_ANGLE),
    .waddr (p1.addr),
    .wdata (p1.data[7:0]),
    .raddr (ang_raddr),
    .rdata (ang_rdata)
  );

  // Stage two.
  pix_t        p2;
  logic [17:0] dx2, dy2;
  logic [18:0] dxp2;
  logic [SQ_W-1:0] n2;
  logic        dxneg2, dypos2, disp2;

  logic signed [19:0] sx_c, sy_c;
  logic signed [10:0] dxp_c;
  logic signed [21:0] sxp_c;

  assign sx_c  = dx1 * dx1;
  assign sy_c  = dy1 * dy1;
  assign dxp_c = 11'(dx1) + 11'sd1;
  assign sxp_c = dxp_c * dxp_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2.valid <= 1'b0;
    end else begin
      p2 <= p1;
    end
  end

  always_ff @(posedge clk) begin
    dx2    <= sx_c[17:0];
    dy2    <= sy_c[17:0];
    dxp2   <= sxp_c[18:0];
    n2     <= SQ_W'(qx1) * SQ_W'(qx1) + SQ_W'(qy1) * SQ_W'(qy1);
    dxneg2 <= dx1[9];
    dypos2 <= !dy1[9] && (dy1 != 10'sd0);
    disp2  <= disp1;
  end

  // Stage three: circle test, region and full angle.
  logic signed [20:0] lim;
  logic [19:0]        dist_sq;
  logic               in_eye;
  logic [7:0]         h8, fa;
  pix_t               p3_c;

  assign lim     = $signed({5'd0, eye_sq}) - $signed({3'd0, dy2});
  assign dist_sq = {2'd0, dx2} + {2'd0, dy2};
  assign in_eye  = disp2 && (dxneg2 ? ($signed({3'd0, dx2}) <= lim)
                                    : ($signed({2'd0, dxp2}) <= lim));
  assign h8      = {1'b0, ang_rdata[7:1]};

  always_comb begin
    if (!dxneg2 && dypos2) begin
      fa = ANG_HALF - h8;
    end else if (dxneg2 && dypos2) begin
      fa = ANG_HALF + h8;
    end else if (dxneg2) begin
      fa = 8'd0 - h8;
    end else begin
      fa = h8;
    end

    p3_c        = p2;
    p3_c.region = REGION_BG;
    p3_c.color  = cfg.solid_colors[15:0];
    p3_c.tex    = 1'b0;
    p3_c.sclera = 1'b0;
    p3_c.ang    = fa + cfg.rotations[7:0];
    if (in_eye) begin
      if (dist_sq <= {4'd0, pupil_sq}) begin
        p3_c.region = REGION_PUPIL;
        p3_c.color  = cfg.solid_colors[31:16];
      end else if (dist_sq <= {4'd0, iris_sq}) begin
        p3_c.region = REGION_IRIS;
        p3_c.color  = cfg.solid_colors[47:32];
        p3_c.tex    = cfg.texture_enable[0];
      end else begin
        p3_c.region = REGION_SCLERA;
        p3_c.color  = cfg.solid_colors[63:48];
        p3_c.tex    = cfg.texture_enable[1];
        p3_c.sclera = 1'b1;
        p3_c.ang    = fa + cfg.rotations[15:8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else begin
      pix_out <= p3_c;
    end
  end

  always_ff @(posedge clk) begin
    n_out <= n2;
  end

endmodule

// ===== rtl/pes_texel.sv =====
// ----------------------------------------------------------------------------
// pes_texel
// Stages seven to ten: radial texture row, texel address, texture memories
// and the result register.
// ----------------------------------------------------------------------------
module pes_texel
  import pes_pkg::*;
#(
  parameter int IRIS_TEX_W   = IRIS_TEX_W_D,
  parameter int IRIS_TEX_H   = IRIS_TEX_H_D,
  parameter int SCLERA_TEX_W = SCLERA_TEX_W_D,
  parameter int SCLERA_TEX_H = SCLERA_TEX_H_D
) (
  input  logic              clk,
  input  logic              rst,
  input  pix_t              pix_in,
  input  logic [ROOT_W-1:0] root,
  input  logic [MUL_W-1:0]  iris_mul,
  input  logic [MUL_W-1:0]  sclera_mul,
  input  logic [7:0]        iris_radius,
  output logic              done,
  output logic [15:0]       color,
  output logic [1:0]        region
);

  localparam int IRIS_DEPTH   = IRIS_TEX_W * IRIS_TEX_H;
  localparam int SCLERA_DEPTH = SCLERA_TEX_W * SCLERA_TEX_H;
  localparam int IAW = addr_bits(IRIS_DEPTH);
  localparam int SAW = addr_bits(SCLERA_DEPTH);

  // Stage seven: radius, saturated, and the sclera offset past the iris.
  pix_t             p7;
  logic [7:0]       rv7;
  logic [MUL_W-1:0] mul7;
  logic [7:0]       r_c;

  assign r_c = root[8] ? 8'd255 : root[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      p7.valid <= 1'b0;
    end else begin
      p7 <= pix_in;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_in.sclera) begin
      rv7  <= (r_c > iris_radius) ? 8'(r_c - iris_radius) : 8'd0;
      mul7 <= sclera_mul;
    end else begin
      rv7  <= r_c;
      mul7 <= iris_mul;
    end
  end

  // Stage eight: Q16 radial scale.
  pix_t        p8;
  logic [32:0] prod8;

  always_ff @(posedge clk) begin
    if (rst) begin
      p8.valid <= 1'b0;
    end else begin
      p8 <= p7;
    end
  end

  always_ff @(posedge clk) begin
    prod8 <= rv7 * mul7;
  end

  // Stage nine: texel address; texture writes happen here as well.
  logic [16:0] v_raw, v_sat, idx;
  logic        oor_c;
  pix_t        p9;
  logic        oor9;
  logic [15:0] iris_rdata, sclera_rdata;

  assign v_raw = prod8[32:16];
  always_comb begin
    if (p8.sclera) begin
      v_sat = (v_raw >= 17'(SCLERA_TEX_H)) ? 17'(SCLERA_TEX_H - 1) : v_raw;
      idx   = {1'b0, p8.ubase} + v_sat;
      oor_c = idx >= 17'(SCLERA_DEPTH);
    end else begin
      v_sat = (v_raw >= 17'(IRIS_TEX_H)) ? 17'(IRIS_TEX_H - 1) : v_raw;
      idx   = {1'b0, p8.ubase} + v_sat;
      oor_c = idx >= 17'(IRIS_DEPTH);
    end
  end

  pes_ram #(.WIDTH(16), .DEPTH(IRIS_DEPTH)) u_iris (
    .clk   (clk),
    .we    (p8.valid && p8.kind == KIND_IRIS && ({1'b0, p8.addr} < 17'(IRIS_DEPTH))),
    .waddr (p8.addr[IAW-1:0]),
    .wdata (p8.data),
    .raddr (idx[IAW-1:0]),
    .rdata (iris_rdata)
  );

  pes_ram #(.WIDTH(16), .DEPTH(SCLERA_DEPTH)) u_sclera (
    .clk   (clk),
    .we    (p8.valid && p8.kind == KIND_SCLERA && ({1'b0, p8.addr} < 17'(SCLERA_DEPTH))),
    .waddr (p8.addr[SAW-1:0]),
    .wdata (p8.data),
    .raddr (idx[SAW-1:0]),
    .rdata (sclera_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p9.valid <= 1'b0;
    end else begin
      p9 <= p8;
    end
  end

  always_ff @(posedge clk) begin
    oor9 <= oor_c;
  end

  // Stage ten: result register; only shade words produce a result.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p9.valid && p9.kind == KIND_SHADE;
    end
  end

  always_ff @(posedge clk) begin
    region <= p9.region;
    if (!p9.tex) begin
      color <= p9.color;
    end else if (oor9) begin
      color <= 16'd0;
    end else begin
      color <= p9.sclera ? sclera_rdata : iris_rdata;
    end
  end

endmodule

// ===== rtl/polar_eye_pixel_shader.sv =====
// ----------------------------------------------------------------------------
// polar_eye_pixel_shader
// Colors display pixels of a round eye with solid or polar textured regions.
// ----------------------------------------------------------------------------
// One input word is taken per clock while busy is low, and every shade word
// gives one color and region on done once it has passed stages one to ten;
// table write words give no result. The output cannot be held off, so the
// receiver must take each result in the cycle it appears. After reset, and
// after each write of eye_radius or iris_radius, busy stays high while two
// shift-subtract dividers form the Q16 texture scales, one quotient bit per
// cycle.
module polar_eye_pixel_shader
  import pes_pkg::*;
#(
  parameter int MAP_RADIUS   = MAP_RADIUS_D,
  parameter int DISPLAY_SIZE = DISPLAY_SIZE_D,
  parameter int IRIS_TEX_W   = IRIS_TEX_W_D,
  parameter int IRIS_TEX_H   = IRIS_TEX_H_D,
  parameter int SCLERA_TEX_W = SCLERA_TEX_W_D,
  parameter int SCLERA_TEX_H = SCLERA_TEX_H_D
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [8:0]  pixel_x,
  input  logic [8:0]  pixel_y,
  input  logic [15:0] table_address,
  input  logic [15:0] table_data,
  output logic        done,
  output logic [15:0] color,
  output logic [1:0]  region,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cfg_t        cfg;
  logic [15:0] eye_sq, pupil_sq, iris_sq;
  logic        recalc;
  logic        iris_busy, sclera_busy;
  logic [MUL_W-1:0] iris_mul, sclera_mul;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x       <= 9'd256;
      cfg.center_y       <= 9'd256;
      cfg.eye_radius     <= 8'd200;
      cfg.iris_radius    <= 8'd100;
      cfg.pupil_radius   <= 8'd50;
      cfg.rotations      <= 16'd0;
      cfg.solid_colors   <= 64'd0;
      cfg.texture_enable <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_X:     cfg.center_x       <= cfg_data[8:0];
        CFG_CENTER_Y:     cfg.center_y       <= cfg_data[8:0];
        CFG_EYE_RADIUS:   cfg.eye_radius     <= cfg_data[7:0];
        CFG_IRIS_RADIUS:  cfg.iris_radius    <= cfg_data[7:0];
        CFG_PUPIL_RADIUS: cfg.pupil_radius   <= cfg_data[7:0];
        CFG_ROTATIONS:    cfg.rotations      <= cfg_data[15:0];
        CFG_SOLID_COLORS: cfg.solid_colors   <= cfg_data;
        CFG_TEX_ENABLE:   cfg.texture_enable <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    eye_sq   <= cfg.eye_radius * cfg.eye_radius;
    pupil_sq <= cfg.pupil_radius * cfg.pupil_radius;
    iris_sq  <= cfg.iris_radius * cfg.iris_radius;
  end

  // The scales are rebuilt starting in the cycle after a radius write, from the new value.
  always_ff @(posedge clk) begin
    if (rst) begin
      recalc <= 1'b1;
    end else begin
      recalc <= cfg_we && (cfg_index == CFG_EYE_RADIUS || cfg_index == CFG_IRIS_RADIUS);
    end
  end

  assign busy = recalc | iris_busy | sclera_busy;

  pes_recip_div #(.DIVIDEND(IRIS_TEX_H * 65536)) u_iris_div (
    .clk      (clk),
    .rst      (rst),
    .go       (recalc),
    .divisor  (cfg.iris_radius),
    .quotient (iris_mul),
    .busy     (iris_busy)
  );

  pes_recip_div #(.DIVIDEND(SCLERA_TEX_H * 65536)) u_sclera_div (
    .clk      (clk),
    .rst      (rst),
    .go       (recalc),
    .divisor  ((cfg.eye_radius > cfg.iris_radius) ? 8'(cfg.eye_radius - cfg.iris_radius)
                                                  : 8'd0),
    .quotient (sclera_mul),
    .busy     (sclera_busy)
  );

  pix_t            p3;
  logic [SQ_W-1:0] n3;

  pes_front #(.MAP_RADIUS(MAP_RADIUS), .DISPLAY_SIZE(DISPLAY_SIZE)) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (start && !busy),
    .kind          (kind),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .table_address (table_address),
    .table_data    (table_data),
    .cfg           (cfg),
    .eye_sq        (eye_sq),
    .pupil_sq      (pupil_sq),
    .iris_sq       (iris_sq),
    .pix_out       (p3),
    .n_out         (n3)
  );

  logic [ROOT_W-1:0] root6;

  pes_isqrt u_isqrt (
    .clk  (clk),
    .n    (n3),
    .root (root6)
  );

  // Stages four to six run beside the square root: texture column and base.
  pix_t        p4, p5, p6;
  pix_t        p5_c;
  logic [7:0]  u4;
  logic [16:0] up_c;

  assign up_c = p3.sclera ? (p3.ang * 9'(SCLERA_TEX_W)) : (p3.ang * 9'(IRIS_TEX_W));

  always_comb begin
    p5_c       = p4;
    p5_c.ubase = p4.sclera ? (16'(u4) * 16'(SCLERA_TEX_H)) : (16'(u4) * 16'(IRIS_TEX_H));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p4.valid <= 1'b0;
      p5.valid <= 1'b0;
      p6.valid <= 1'b0;
    end else begin
      p4 <= p3;
      p5 <= p5_c;
      p6 <= p5;
    end
  end

  always_ff @(posedge clk) begin
    u4 <= up_c[15:8];
  end

  pes_texel #(
    .IRIS_TEX_W   (IRIS_TEX_W),
    .IRIS_TEX_H   (IRIS_TEX_H),
    .SCLERA_TEX_W (SCLERA_TEX_W),
    .SCLERA_TEX_H (SCLERA_TEX_H)
  ) u_texel (
    .clk         (clk),
    .rst         (rst),
    .pix_in      (p6),
    .root        (root6),
    .iris_mul    (iris_mul),
    .sclera_mul  (sclera_mul),
    .iris_radius (cfg.iris_radius),
    .done        (done),
    .color       (color),
    .region      (region)
  );

endmodule

// ===== rtl/pes_checker.sv =====
// ----------------------------------------------------------------------------
// pes_checker
// Port-level checks of the shader's busy and result behavior.
// ----------------------------------------------------------------------------
module pes_checker
  import pes_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       busy,
  input logic       done,
  input logic       cfg_we,
  input logic [2:0] cfg_index
);

  // Scale rebuild starts straight out of reset.
  a_busy_after_reset: assert property (@(posedge clk) $past(rst) && !rst |-> busy)
    else $error("busy low right after reset");

  // A radius write must hold off new words while the scales are rebuilt.
  a_busy_after_radius: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == CFG_EYE_RADIUS || cfg_index == CFG_IRIS_RADIUS) |=> busy)
    else $error("radius write did not raise busy");

  // Users raise busy only on a drained pipeline (unenforced): no done then.
  a_no_done_busy: assert property (@(posedge clk) disable iff (rst) busy |-> !done)
    else $error("result word while busy");

  // Busy rises only after reset or a radius write.
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(cfg_we) &&
      ($past(cfg_index) == CFG_EYE_RADIUS || $past(cfg_index) == CFG_IRIS_RADIUS))
    else $error("busy rose without a radius write");

endmodule

bind polar_eye_pixel_shader pes_checker u_pes_checker (.*);
